FILE: rtl/nsts_pkg.sv
// ============================================================================
// nsts_pkg
// Types, command codes and helpers for the note state table with snapshot.
// ============================================================================
package nsts_pkg;

  localparam int NOTE_COUNT_DEF = 128;
  localparam int NOTE_W         = 7;
  localparam int VEL_W          = 7;
  localparam int CH_W           = 4;

  typedef enum logic [1:0] {
    CMD_ON    = 2'd0,
    CMD_OFF   = 2'd1,
    CMD_SNAP  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [NOTE_W-1:0] note;
    logic [CH_W-1:0]   channel;
    logic [VEL_W-1:0]  velocity;
    logic              auto_channel;
  } in_t;

  typedef struct packed {
    logic              note_active;
    logic              was_active;
    logic              changed;
    logic [VEL_W-1:0]  velocity_now;
    logic [VEL_W-1:0]  velocity_before;
    logic [CH_W-1:0]   channel_now;
    logic              channel_now_valid;
    logic [CH_W-1:0]   channel_before;
    logic              channel_before_valid;
    logic [CH_W-1:0]   channel_used;
  } out_t;

  // one note's stored state
  typedef struct packed {
    logic              active;
    logic [VEL_W-1:0]  vel;
    logic              ch_valid;
    logic [CH_W-1:0]   ch;
  } entry_t;

  // note mod 12: quotient via reciprocal 43/512, exact for 0..127
  function automatic logic [CH_W-1:0] mod12(input logic [NOTE_W-1:0] n);
    logic [12:0] prod;
    logic [3:0]  q;
    logic [7:0]  qx12;
    logic [7:0]  rem;
    prod = 13'(n) * 13'd43;
    q    = prod[12:9];
    qx12 = 8'(q) * 8'd12;
    rem  = 8'(n) - qx12;
    return rem[CH_W-1:0];
  endfunction

endpackage

FILE: rtl/note_state_table_with_snapshot_top.sv
// ============================================================================
// note_state_table_with_snapshot_top
// Per-note active/velocity/channel state with a one-step snapshot copy.
// ============================================================================
// Usage:
//   A request is taken on a rising edge with start high and busy low. busy
//   is held low, so a request may be issued on every cycle.
//   Commands: note on, note off, snapshot, query. Each request produces one
//   result describing the addressed note after the request took effect.
//   Timing: the request is registered at acceptance; the tables update and
//   the result is registered on the next edge, together with out_valid,
//   which is high for one cycle per request.
//   Throughput: one request per cycle; the snapshot copies all entries in
//   parallel, as the tables are flip-flops.
//   Reset (rst_n low, synchronous) clears all pipeline valids, sets every
//   active bit, velocity and change bit to zero and every channel to invalid.
//   Results cannot be stalled; the receiver must take out_res whenever
//   out_valid is high.
// ============================================================================
module note_state_table_with_snapshot_top #(
  parameter int NOTE_COUNT = nsts_pkg::NOTE_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  nsts_pkg::in_t  in_req,
  output logic           out_valid,
  output nsts_pkg::out_t out_res
);

  logic           req_valid_r;
  logic           req_valid_nxt;
  nsts_pkg::in_t  req_r;
  logic           out_valid_r;
  logic           out_valid_nxt;
  nsts_pkg::out_t out_res_r;
  nsts_pkg::out_t res;

  assign busy          = 1'b0;
  assign req_valid_nxt = start && !busy;
  assign out_valid_nxt = req_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid_nxt) begin
      req_r <= in_req;
    end
    if (req_valid_r) begin
      out_res_r <= res;
    end
  end

  nsts_store #(
    .NOTE_COUNT(NOTE_COUNT)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(req_valid_r),
    .req      (req_r),
    .res      (res)
  );

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

FILE: rtl/nsts_store.sv
// ============================================================================
// nsts_store
// Current, snapshot and change tables in flip-flops; applies one request per
// cycle and returns the addressed note's state after the update.
// ============================================================================
module nsts_store #(
  parameter int NOTE_COUNT = nsts_pkg::NOTE_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           req_valid,
  input  nsts_pkg::in_t  req,
  output nsts_pkg::out_t res
);

  localparam int IDX_W = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;

  nsts_pkg::entry_t cur_r  [NOTE_COUNT];
  nsts_pkg::entry_t snap_r [NOTE_COUNT];
  logic             chg_r  [NOTE_COUNT];

  logic [IDX_W-1:0]              idx;
  logic                          in_range;
  logic                          is_note_cmd;
  logic [nsts_pkg::CH_W-1:0]     used;
  nsts_pkg::entry_t              cur_e;
  nsts_pkg::entry_t              snap_e;
  logic                          chg_e;
  nsts_pkg::entry_t              new_e;
  nsts_pkg::entry_t              now_e;
  nsts_pkg::entry_t              before_e;
  logic                          chg_now;

  always_comb begin
    idx         = req.note[IDX_W-1:0];
    in_range    = {1'b0, req.note} < 8'(NOTE_COUNT);
    is_note_cmd = (req.cmd == nsts_pkg::CMD_ON) || (req.cmd == nsts_pkg::CMD_OFF);
    used        = '0;
    if (is_note_cmd) begin
      used = req.auto_channel ? nsts_pkg::mod12(req.note) : req.channel;
    end

    cur_e  = cur_r[idx];
    snap_e = snap_r[idx];
    chg_e  = chg_r[idx];

    new_e = '0;
    if (req.cmd == nsts_pkg::CMD_ON) begin
      new_e.active   = 1'b1;
      new_e.vel      = req.velocity;
      new_e.ch_valid = 1'b1;
      new_e.ch       = used;
    end

    now_e    = cur_e;
    before_e = snap_e;
    chg_now  = chg_e;
    unique case (req.cmd) inside
      nsts_pkg::CMD_ON, nsts_pkg::CMD_OFF: begin
        now_e = new_e;
      end
      nsts_pkg::CMD_SNAP: begin
        before_e = cur_e;
        chg_now  = cur_e.active ^ snap_e.active;
      end
      nsts_pkg::CMD_QUERY: begin
      end
    endcase

    if (!in_range) begin
      now_e    = '0;
      before_e = '0;
      chg_now  = 1'b0;
    end

    res.note_active          = now_e.active;
    res.was_active           = before_e.active;
    res.changed              = chg_now;
    res.velocity_now         = now_e.vel;
    res.velocity_before      = before_e.vel;
    res.channel_now          = now_e.ch_valid ? now_e.ch : '0;
    res.channel_now_valid    = now_e.ch_valid;
    res.channel_before       = before_e.ch_valid ? before_e.ch : '0;
    res.channel_before_valid = before_e.ch_valid;
    res.channel_used         = used;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NOTE_COUNT; i++) begin
        cur_r[i]  <= '0;
        snap_r[i] <= '0;
        chg_r[i]  <= 1'b0;
      end
    end else if (req_valid) begin
      unique case (req.cmd) inside
        nsts_pkg::CMD_ON, nsts_pkg::CMD_OFF: begin
          if (in_range) begin
            cur_r[idx] <= new_e;
          end
        end
        nsts_pkg::CMD_SNAP: begin
          for (int i = 0; i < NOTE_COUNT; i++) begin
            chg_r[i]  <= cur_r[i].active ^ snap_r[i].active;
            snap_r[i] <= cur_r[i];
          end
        end
        nsts_pkg::CMD_QUERY: begin
        end
      endcase
    end
  end

endmodule
